// File: hdl/papf_pkg.sv
// Shared types and constants of the projected annulus point filter.
package papf_pkg;

	localparam int COORD_W = 32;
	localparam int DEN_W   = 47;            // z * 2^16 with z positive
	localparam int QB      = 14;            // quotient bits kept before overflow
	localparam int REM_W   = DEN_W + QB;    // remainder width after the overflow check

	typedef enum logic [2:0] {
		REG_FOCAL_X     = 3'd0,
		REG_FOCAL_Y     = 3'd1,
		REG_PRINCIPAL_X = 3'd2,
		REG_PRINCIPAL_Y = 3'd3,
		REG_BOX_CENTER_X = 3'd4,
		REG_BOX_CENTER_Y = 3'd5,
		REG_BOX_SIZE_X  = 3'd6,
		REG_BOX_SIZE_Y  = 3'd7
	} cfg_reg_t;

	// Fields that travel unchanged to the output.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               last;
	} pass_t;

	// One step of the two restoring dividers.
	typedef struct packed {
		pass_t            pass;
		logic             ok;
		logic [DEN_W-1:0] den;
		logic             ovf_u;
		logic             neg_u;
		logic [REM_W-1:0] rem_u;
		logic [QB-1:0]    q_u;
		logic             ovf_v;
		logic             neg_v;
		logic [REM_W-1:0] rem_v;
		logic [QB-1:0]    q_v;
	} div_t;

endpackage

// File: hdl/projected_annulus_point_filter_unit.sv
// Projected annulus point filter: projection, exact division and ellipse tests.
// One point enters per clock while the pipeline advances, and its word leaves through
// the 24 register stages: abs, products, signed sum, magnitude, overflow check, fourteen
// restoring quotient steps (one bit each for u and v in parallel), then box offset,
// two multiplier levels, sum and the final compare. The whole pipeline advances whenever
// the output register is empty or its word is taken, so a stall holds every stage.
// Register writes are taken at any time but must only be issued while the pipeline is
// empty. Points whose depth is invalid or not positive pass through with keep low.
module projected_annulus_point_filter_unit #(
	parameter int unsigned ANNULUS_RATIO_Q8 = 128
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [95:0]             s_axis_tdata,   // point_x, point_y, point_z
	input  logic                    s_axis_tuser,   // depth_valid
	input  logic                    s_axis_tlast,   // last_point
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [95:0]             m_axis_tdata,   // out_x, out_y, out_z
	output logic                    m_axis_tuser,   // keep
	output logic                    m_axis_tlast,   // out_last
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [31:0]             cfg_data
);
	import papf_pkg::*;

	localparam logic [7:0]  RATIO = 8'(ANNULUS_RATIO_Q8);
	localparam logic [15:0] R2    = {8'd0, RATIO} * {8'd0, RATIO};

	logic [31:0] fx_q, fy_q, px_q, py_q;
	logic [15:0] cx_q, cy_q, rx_q, ry_q;

	logic adv;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q <= '0;
			fy_q <= '0;
			px_q <= '0;
			py_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			rx_q <= '0;
			ry_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:      fx_q <= cfg_data;
				REG_FOCAL_Y:      fy_q <= cfg_data;
				REG_PRINCIPAL_X:  px_q <= cfg_data;
				REG_PRINCIPAL_Y:  py_q <= cfg_data;
				REG_BOX_CENTER_X: cx_q <= cfg_data[15:0];
				REG_BOX_CENTER_Y: cy_q <= cfg_data[15:0];
				REG_BOX_SIZE_X:   rx_q <= cfg_data[15:0];
				REG_BOX_SIZE_Y:   ry_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Valid bits of the front stages, the divider and the back stages.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic div_vld [0:QB];
	logic vld_s20, vld_s21, vld_s22, vld_s23, vld_s24;

	assign adv           = !vld_s24 || m_axis_tready;
	assign s_axis_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s20 <= 1'b0;
			vld_s21 <= 1'b0;
			vld_s22 <= 1'b0;
			vld_s23 <= 1'b0;
			vld_s24 <= 1'b0;
		end else if (adv) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s20 <= div_vld[QB];
			vld_s21 <= vld_s20;
			vld_s22 <= vld_s21;
			vld_s23 <= vld_s22;
			vld_s24 <= vld_s23;
		end
	end

	// Stage 1: take the point apart into sign and magnitude.
	pass_t       pass_s1;
	logic        ok_s1, sx_s1, sy_s1;
	logic [31:0] ax_s1, ay_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s1.x    <= s_axis_tdata[31:0];
			pass_s1.y    <= s_axis_tdata[63:32];
			pass_s1.z    <= s_axis_tdata[95:64];
			pass_s1.last <= s_axis_tlast;
			ok_s1 <= s_axis_tuser && !s_axis_tdata[95] && (s_axis_tdata[95:64] != 32'd0);
			sx_s1 <= s_axis_tdata[31];
			sy_s1 <= s_axis_tdata[63];
			ax_s1 <= s_axis_tdata[31] ? (~s_axis_tdata[31:0] + 32'd1) : s_axis_tdata[31:0];
			ay_s1 <= s_axis_tdata[63] ? (~s_axis_tdata[63:32] + 32'd1) : s_axis_tdata[63:32];
		end
	end

	// Stage 2: the numerator terms |p|*f and c*z, and the denominator z*2^16.
	pass_t            pass_s2;
	logic             ok_s2, sx_s2, sy_s2;
	logic [63:0]      mx_s2, my_s2;
	logic [62:0]      bx_s2, by_s2;
	logic [DEN_W-1:0] den_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s2 <= pass_s1;
			ok_s2   <= ok_s1;
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			mx_s2   <= 64'(ax_s1) * 64'(fx_q);
			my_s2   <= 64'(ay_s1) * 64'(fy_q);
			bx_s2   <= 63'(px_q) * 63'(pass_s1.z[30:0]);
			by_s2   <= 63'(py_q) * 63'(pass_s1.z[30:0]);
			den_s2  <= {pass_s1.z[30:0], 16'd0};
		end
	end

	// Stage 3: signed numerators.
	pass_t            pass_s3;
	logic             ok_s3;
	logic [64:0]      nx_s3, ny_s3;
	logic [DEN_W-1:0] den_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s3 <= pass_s2;
			ok_s3   <= ok_s2;
			den_s3  <= den_s2;
			nx_s3   <= sx_s2 ? ({2'b0, bx_s2} - {1'b0, mx_s2}) : ({2'b0, bx_s2} + {1'b0, mx_s2});
			ny_s3   <= sy_s2 ? ({2'b0, by_s2} - {1'b0, my_s2}) : ({2'b0, by_s2} + {1'b0, my_s2});
		end
	end

	// Stage 4: magnitudes of the numerators; the quotient is truncated toward zero.
	pass_t            pass_s4;
	logic             ok_s4, negx_s4, negy_s4;
	logic [63:0]      magx_s4, magy_s4;
	logic [DEN_W-1:0] den_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s4 <= pass_s3;
			ok_s4   <= ok_s3;
			den_s4  <= den_s3;
			negx_s4 <= nx_s3[64];
			negy_s4 <= ny_s3[64];
			magx_s4 <= nx_s3[64] ? (~nx_s3[63:0] + 64'd1) : nx_s3[63:0];
			magy_s4 <= ny_s3[64] ? (~ny_s3[63:0] + 64'd1) : ny_s3[63:0];
		end
	end

	// Stage 5: a quotient of 2^14 or more lies far outside any box.
	logic [63:0] lim_s4;
	div_t        div_s [0:QB];

	assign lim_s4 = 64'({den_s4, {QB{1'b0}}});
	assign div_vld[0] = vld_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			div_s[0].pass  <= pass_s4;
			div_s[0].ok    <= ok_s4;
			div_s[0].den   <= den_s4;
			div_s[0].ovf_u <= magx_s4 >= lim_s4;
			div_s[0].neg_u <= negx_s4;
			div_s[0].rem_u <= magx_s4[REM_W-1:0];
			div_s[0].q_u   <= '0;
			div_s[0].ovf_v <= magy_s4 >= lim_s4;
			div_s[0].neg_v <= negy_s4;
			div_s[0].rem_v <= magy_s4[REM_W-1:0];
			div_s[0].q_v   <= '0;
		end
	end

	// Stages 6 to 19: one restoring quotient bit per stage, most significant first.
	for (genvar j = 1; j <= QB; j++) begin : g_div
		localparam int K = QB - j;
		logic [REM_W-1:0] dsh;
		logic             ge_u, ge_v;
		div_t             nxt;

		assign dsh  = REM_W'(div_s[j-1].den) << K;
		assign ge_u = div_s[j-1].rem_u >= dsh;
		assign ge_v = div_s[j-1].rem_v >= dsh;

		always_comb begin
			nxt = div_s[j-1];
			if (ge_u) begin
				nxt.rem_u = div_s[j-1].rem_u - dsh;
			end
			if (ge_v) begin
				nxt.rem_v = div_s[j-1].rem_v - dsh;
			end
			nxt.q_u[K] = ge_u;
			nxt.q_v[K] = ge_v;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_vld[j] <= 1'b0;
			end else if (adv) begin
				div_vld[j] <= div_vld[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_s[j] <= nxt;
			end
		end
	end

	// Stage 20: pixel offsets from the box center in 1/32 pixel and the box test.
	div_t               dq;
	logic signed [14:0] u, v;
	logic signed [20:0] dx, dy;
	logic [19:0]        a, b;

	assign dq = div_s[QB];

	always_comb begin
		u  = dq.neg_u ? -$signed({1'b0, dq.q_u}) : $signed({1'b0, dq.q_u});
		v  = dq.neg_v ? -$signed({1'b0, dq.q_v}) : $signed({1'b0, dq.q_v});
		dx = {{1{u[14]}}, u, 5'd0} - $signed({4'd0, cx_q, 1'b0});
		dy = {{1{v[14]}}, v, 5'd0} - $signed({4'd0, cy_q, 1'b0});
		a  = dx[20] ? 20'(-dx) : dx[19:0];
		b  = dy[20] ? 20'(-dy) : dy[19:0];
	end

	pass_t       pass_s20;
	logic        in_s20;
	logic [15:0] a_s20, b_s20;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s20 <= dq.pass;
			in_s20   <= dq.ok && !dq.ovf_u && !dq.ovf_v && (rx_q != 16'd0) && (ry_q != 16'd0)
				&& (a <= 20'(rx_q)) && (b <= 20'(ry_q));
			a_s20    <= a[15:0];
			b_s20    <= b[15:0];
		end
	end

	// Stage 21: cross terms a*ry, b*rx and rx*ry.
	pass_t       pass_s21;
	logic        in_s21;
	logic [31:0] ar_s21, br_s21, rr_s21;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s21 <= pass_s20;
			in_s21   <= in_s20;
			ar_s21   <= 32'(a_s20) * 32'(ry_q);
			br_s21   <= 32'(b_s20) * 32'(rx_q);
			rr_s21   <= 32'(rx_q) * 32'(ry_q);
		end
	end

	// Stage 22: squares.
	pass_t       pass_s22;
	logic        in_s22;
	logic [63:0] sa_s22, sb_s22, t_s22;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s22 <= pass_s21;
			in_s22   <= in_s21;
			sa_s22   <= 64'(ar_s21) * 64'(ar_s21);
			sb_s22   <= 64'(br_s21) * 64'(br_s21);
			t_s22    <= 64'(rr_s21) * 64'(rr_s21);
		end
	end

	// Stage 23: ellipse sum and the inner bound scaled by the squared ratio.
	pass_t       pass_s23;
	logic        in_s23;
	logic [64:0] s_s23;
	logic [63:0] t_s23;
	logic [79:0] tr_s23;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s23 <= pass_s22;
			in_s23   <= in_s22;
			s_s23    <= {1'b0, sa_s22} + {1'b0, sb_s22};
			t_s23    <= t_s22;
			tr_s23   <= 80'(t_s22) * 80'(R2);
		end
	end

	// Stage 24: output register. Inside the outer ellipse and strictly outside the inner.
	pass_t pass_s24;
	logic  keep_s24;

	always_ff @(posedge clk) begin
		if (adv) begin
			pass_s24 <= pass_s23;
			keep_s24 <= in_s23 && (s_s23 <= {1'b0, t_s23})
				&& ({s_s23, 16'd0} > {1'b0, tr_s23});
		end
	end

	assign m_axis_tvalid = vld_s24;
	assign m_axis_tdata  = {pass_s24.z, pass_s24.y, pass_s24.x};
	assign m_axis_tuser  = keep_s24;
	assign m_axis_tlast  = pass_s24.last;

`ifndef SYNTH
	a_rem_u: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld[QB] && dq.ok && !dq.ovf_u |-> dq.rem_u < REM_W'(dq.den))
		else $error("u remainder not below divisor");
	a_rem_v: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld[QB] && dq.ok && !dq.ovf_v |-> dq.rem_v < REM_W'(dq.den))
		else $error("v remainder not below divisor");
	a_keep_box: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> rx_q != 16'd0 && ry_q != 16'd0)
		else $error("point kept with a degenerate box");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_s1) && $stable(div_vld[QB]) && $stable(vld_s23))
		else $error("pipeline moved during a stall");
`endif

endmodule

// File: tb/tb_projected_annulus_point_filter_unit.sv
// Self-checking testbench of the projected annulus point filter: directed and random points.
`timescale 1ns / 100ps

module tb_projected_annulus_point_filter_unit;
	import papf_pkg::*;

	localparam int RATIO_Q8    = 128;
	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_WAIT  = 40;

	typedef struct {
		bit          keep;
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		bit          last;
	} point_word_t;

	// Keeps the register copy, predicts the keep flag and matches output words in order.
	class point_scoreboard;
		point_word_t pending[$];
		logic [31:0] focal_x, focal_y, principal_x, principal_y;
		logic [15:0] ctr_col, ctr_row, size_x, size_y;
		int          errors;
		int          words_seen;
		int          kept;

		function new();
			errors = 0;
			words_seen = 0;
			kept = 0;
			set_reg(REG_FOCAL_X, '0);
			set_reg(REG_FOCAL_Y, '0);
			set_reg(REG_PRINCIPAL_X, '0);
			set_reg(REG_PRINCIPAL_Y, '0);
			set_reg(REG_BOX_CENTER_X, '0);
			set_reg(REG_BOX_CENTER_Y, '0);
			set_reg(REG_BOX_SIZE_X, '0);
			set_reg(REG_BOX_SIZE_Y, '0);
		endfunction

		function void set_reg(cfg_reg_t idx, logic [31:0] value);
			case (idx)
				REG_FOCAL_X:      focal_x = value;
				REG_FOCAL_Y:      focal_y = value;
				REG_PRINCIPAL_X:  principal_x = value;
				REG_PRINCIPAL_Y:  principal_y = value;
				REG_BOX_CENTER_X: ctr_col = value[15:0];
				REG_BOX_CENTER_Y: ctr_row = value[15:0];
				REG_BOX_SIZE_X:   size_x = value[15:0];
				REG_BOX_SIZE_Y:   size_y = value[15:0];
				default: ;
			endcase
		endfunction

		// Pixel index truncated toward zero: (p*f + c*z) / (z * 2^16).
		function logic signed [127:0] pixel_of(logic signed [31:0] p, logic [31:0] f,
				logic [31:0] c, logic signed [31:0] z);
			logic signed [127:0] ps, fs, cs, zs, num;
			ps = p;
			zs = z;
			fs = {96'b0, f};
			cs = {96'b0, c};
			num = ps * fs + cs * zs;
			return num / (zs <<< 16);
		endfunction

		function bit annulus_hit(logic signed [127:0] u, logic signed [127:0] v);
			logic signed [127:0] dx, dy;
			logic [127:0] a, b, rx, ry, s, t, ratio;
			// Offsets are in 1/32 pixel, where the radius equals the Q12.4 size.
			dx = u * 32 - 128'(ctr_col) * 2;
			dy = v * 32 - 128'(ctr_row) * 2;
			a = dx < 0 ? -dx : dx;
			b = dy < 0 ? -dy : dy;
			rx = size_x;
			ry = size_y;
			ratio = RATIO_Q8 & 8'hFF;
			if (rx == 0 || ry == 0 || a > rx || b > ry)
				return 1'b0;
			s = (a * ry) * (a * ry) + (b * rx) * (b * rx);
			t = (rx * ry) * (rx * ry);
			if (s > t)
				return 1'b0;
			return (s << 16) > t * ratio * ratio;
		endfunction

		function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
				bit depth_ok, bit last);
			point_word_t w;
			w.keep = 1'b0;
			if (depth_ok && $signed(z) > 0)
				w.keep = annulus_hit(pixel_of(x, focal_x, principal_x, z),
					pixel_of(y, focal_y, principal_y, z));
			w.x = x;
			w.y = y;
			w.z = z;
			w.last = last;
			pending = {pending, w};
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("MISMATCH word %0d %s: got %h expected %h", words_seen, what, got, want);
		endtask

		task check_word(point_word_t got);
			point_word_t want;
			words_seen++;
			if (pending.size() == 0) begin
				report_mismatch("unexpected word", got.x, '0);
				return;
			end
			want = pending.pop_front();
			if (want.keep)
				kept++;
			if (got.keep !== want.keep)
				report_mismatch("keep", 32'(got.keep), 32'(want.keep));
			if (got.x !== want.x) report_mismatch("x", got.x, want.x);
			if (got.y !== want.y) report_mismatch("y", got.y, want.y);
			if (got.z !== want.z) report_mismatch("z", got.z, want.z);
			if (got.last !== want.last)
				report_mismatch("last", 32'(got.last), 32'(want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	point_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int cycles = 0;
	int points_sent = 0;
	int settings_used = 0;

	projected_annulus_point_filter_unit #(.ANNULUS_RATIO_Q8(RATIO_Q8)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	// Handshakes are observed with the values held just before the edge.
	always @(posedge clk) begin
		point_word_t got;
		cycles++;
		if (arst_n && s_axis_tvalid && s_axis_tready)
			sb.note_point(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tdata[95:64],
				s_axis_tuser, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.keep = m_axis_tuser;
			got.x = m_axis_tdata[31:0];
			got.y = m_axis_tdata[63:32];
			got.z = m_axis_tdata[95:64];
			got.last = m_axis_tlast;
			sb.check_word(got);
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(negedge clk)
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);

	task automatic write_setting(input logic [31:0] vals[8]);
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(cfg_reg_t'(i), vals[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
			bit depth_ok, bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {z, y, x};
		s_axis_tuser <= depth_ok;
		s_axis_tlast <= last;
		do @(posedge clk); while (!s_axis_tready);
		points_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	// Coordinate that lands near a wanted pixel offset at depth z; f and off in pixels.
	function automatic logic [31:0] aim(longint off, longint f, longint z);
		longint v;
		if (f == 0)
			return 32'($signed($urandom_range(65535)) - 32768);
		v = off * z / f;
		if (v > 64'sh7FFFFFFF) v = 64'sh7FFFFFFF;
		if (v < -64'sh80000000) v = -64'sh80000000;
		return 32'(v);
	endfunction

	task automatic random_points(int count);
		longint fx, fy, offx, offy, z;
		int spanx, spany;
		for (int n = 0; n < count; n++) begin
			if (n % 100 == 0) begin
				case ((n / 100) % 4)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
					default: begin send_idle_pct = 26; recv_stall_pct = 26; end
				endcase
			end
			if ($urandom_range(99) < 20) begin
				send_point($urandom, $urandom, $urandom, 1'($urandom_range(1)),
					1'($urandom_range(1)));
			end else begin
				fx = sb.focal_x >> 16;
				fy = sb.focal_y >> 16;
				spanx = sb.size_x / 16 + 4;
				spany = sb.size_y / 16 + 4;
				offx = longint'(sb.ctr_col / 16) - longint'(sb.principal_x >> 16)
					+ $signed($urandom_range(2 * spanx)) - spanx / 2 - spanx / 4;
				offy = longint'(sb.ctr_row / 16) - longint'(sb.principal_y >> 16)
					+ $signed($urandom_range(2 * spany)) - spany / 2 - spany / 4;
				z = ($urandom_range(15) == 0) ? longint'($urandom_range(1, 32'h7FFFFFFF))
					: longint'($urandom_range(32768, 20 << 16));
				send_point(aim(offx, fx, z), aim(offy, fy, z), 32'(z),
					$urandom_range(15) != 0, $urandom_range(15) == 0);
			end
		end
	endtask

	initial begin
		logic [31:0] cam_a[8] = '{500 << 16, 480 << 16, 320 << 16, 240 << 16,
			320 * 16, 240 * 16, 200 * 16, 160 * 16};
		logic [31:0] cam_b[8] = '{32'h04B2_8000, 32'h04AF_4000, 32'h0280_C000, 32'h01E0_2000,
			16'h2A37, 16'h1C09, 16'h0F23, 16'h0C11};
		logic [31:0] tiny[8] = '{300 << 16, 300 << 16, 100 << 16, 100 << 16,
			16'h0648, 16'h0648, 16'h0001, 16'h0010};
		logic [31:0] top[8] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
			32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF};
		logic [31:0] zero[8] = '{0, 0, 0, 0, 0, 0, 0, 0};

		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		write_setting(cam_a);

		// Directed points: exact center, flags, depth extremes, coordinate extremes.
		send_point(0, 0, 1 << 16, 1, 0);
		send_point(0, 0, 1 << 16, 0, 1);
		send_point(32'h0000_6666, 0, 1 << 16, 0, 0);
		send_point(32'h0000_6666, 0, 1 << 16, 1, 0);
		send_point(32'h0000_3333, 32'h0000_2222, 0, 1, 0);
		send_point(32'h0000_3333, 32'h0000_2222, 32'hFFFF_0000, 1, 0);
		send_point(32'h0000_3333, 32'h0000_2222, 32'h8000_0000, 1, 0);
		send_point(0, 0, 1, 1, 0);
		send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1, 1);
		send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_0000, 1, 0);
		send_point(32'h0000_CCCC, 0, 1 << 16, 1, 0);
		send_point(32'h0000_CCCD, 0, 1 << 16, 1, 0);
		send_point(32'hFFFF_3333, 32'hFFFF_5555, 1 << 16, 1, 0);
		send_point(32'h0000_199A, 0, 1 << 16, 1, 0);
		send_point(0, 32'h0000_5555, 1 << 16, 1, 1);
		drain();

		random_points(500);
		drain();
		write_setting(cam_b);
		random_points(200);
		// Hold the stream until the pipeline is empty, then go on without new settings.
		drain();
		random_points(300);
		drain();
		write_setting(tiny);
		random_points(300);
		drain();
		write_setting(top);
		random_points(300);
		drain();
		write_setting(zero);
		random_points(100);
		drain();
		write_setting(cam_a);
		random_points(300);
		drain();

		$display("Sent %0d points over %0d register settings; %0d words checked, %0d kept.",
			points_sent, settings_used, sb.words_seen, sb.kept);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", sb.errors);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/papf_pkg.sv
hdl/projected_annulus_point_filter_unit.sv
tb/tb_projected_annulus_point_filter_unit.sv
